### rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // Field widths fixed by the request and response formats.
   localparam int SIZE_W   = 16;
   localparam int HEAP_W   = 16;
   localparam int STATUS_W = 2;

   // Defaults for the top-level parameters.
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int ADDR_BITS_DEF  = 16;

   // Heap size after reset.
   localparam logic [HEAP_W-1:0] HEAP_SIZE_RESET = 16'd10000;

   // Request opcodes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_BASE  = 2'd2,
      ST_REJECT   = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;   // Latch the request, start a scan at entry 0.
      logic       scan_step;  // Step past the current entry.
      logic       ins_start;  // Remember insert position, start at the last entry.
      logic       del_start;  // Step to the entry after the one being freed.
      logic       up_step;    // Move one entry up by one slot.
      logic       dn_step;    // Move one entry down by one slot.
      logic       ins_write;  // Write the new entry and grow the table.
      logic       del_done;   // Shrink the table by one entry.
      logic       rsp_load;   // Load the response register.
      status_type rsp_status; // Status for the response register.
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;    // Latched request is a free.
      logic zero_size;  // Latched size is zero.
      logic full;       // Table holds the maximum number of entries.
      logic at_end;     // Scan index has reached the entry count.
      logic fit;        // Request fits ahead of the current entry or heap end.
      logic match;      // Current entry base equals the base to free.
      logic idx_last;   // Index points at the last valid entry.
      logic idx_at_pos; // Index equals the insert position.
   } dp_sts_type;

endpackage

### rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Entry table memory, scan and shift registers, heap size register and the
// response payload register of the first-fit block allocator.
// ----------------------------------------------------------------------------
module ffba_datapath
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_command,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [SIZE_W-1:0]   req_base,
   input  logic                csr_we,
   input  logic [HEAP_W-1:0]   csr_data,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SIZE_W-1:0]   rsp_granted
);

   localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ENTRY_W = 2 * ADDR_BITS;
   localparam int SUM_W   = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;

   // Table storage: base in the upper half, length in the lower half.
   logic [ENTRY_W-1:0] entry_ff [MAX_BLOCKS];
   logic [ENTRY_W-1:0] rd_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [SUM_W-1:0]   prev_end_ff, prev_end_in;
   logic               is_free_ff, is_free_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  base_ff, base_in;
   logic [HEAP_W-1:0]  heap_ff, heap_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SIZE_W-1:0]  rsp_granted_ff, rsp_granted_in;

   logic [CNT_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   wr_addr;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_BITS-1:0] rd_base;
   logic [ADDR_BITS-1:0] rd_len;
   logic [SUM_W-1:0]   end_sum;
   logic [SUM_W-1:0]   need_sum;
   logic [SUM_W-1:0]   limit;
   logic [SUM_W-1:0]   size_ext;
   logic [CNT_W:0]     idx_next_wide;

   assign rd_base  = rd_ff[ENTRY_W-1:ADDR_BITS];
   assign rd_len   = rd_ff[ADDR_BITS-1:0];
   assign size_ext = SUM_W'(size_ff);

   // End of the current entry, and end of the request placed after prev_end.
   assign end_sum  = SUM_W'(rd_base) + SUM_W'(rd_len);
   assign need_sum = prev_end_ff + size_ext;
   assign limit    = (idx_ff == count_ff) ? SUM_W'(heap_ff) : SUM_W'(rd_base);
   assign idx_next_wide = {1'b0, idx_ff} + {{CNT_W{1'b0}}, 1'b1};

   // Status toward the controller.
   always_comb begin
      sts.is_free    = is_free_ff;
      sts.zero_size  = (size_ff == '0);
      sts.full       = (count_ff == CNT_W'(MAX_BLOCKS));
      sts.at_end     = (idx_ff == count_ff);
      sts.fit        = (need_sum <= limit);
      sts.match      = (SUM_W'(rd_base) == SUM_W'(base_ff));
      sts.idx_last   = (idx_next_wide == {1'b0, count_ff});
      sts.idx_at_pos = (idx_ff == pos_ff);
   end

   // Read address for the registered table read.
   always_comb begin
      if (cmd.load_req) begin
         rd_addr = '0;
      end else if (cmd.ins_start) begin
         rd_addr = count_ff - CNT_W'(1);
      end else if (cmd.up_step) begin
         rd_addr = idx_ff - CNT_W'(1);
      end else begin
         rd_addr = idx_ff + CNT_W'(1);
      end
   end

   // Table write: entry moves during shifts, the new entry on insert.
   always_comb begin
      wr_en   = cmd.up_step | cmd.dn_step | cmd.ins_write;
      wr_data = rd_ff;
      if (cmd.up_step) begin
         wr_addr = idx_ff + CNT_W'(1);
      end else if (cmd.dn_step) begin
         wr_addr = idx_ff - CNT_W'(1);
      end else begin
         wr_addr = pos_ff;
         wr_data = {prev_end_ff[ADDR_BITS-1:0], size_ext[ADDR_BITS-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      rd_ff <= entry_ff[rd_addr[IDX_W-1:0]];
   end

   // Request, scan and shift registers.
   always_comb begin
      is_free_in  = is_free_ff;
      size_in     = size_ff;
      base_in     = base_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      prev_end_in = prev_end_ff;
      if (cmd.load_req) begin
         is_free_in  = (req_command == CMD_FREE);
         size_in     = req_size;
         base_in     = req_base;
         idx_in      = '0;
         prev_end_in = '0;
      end else if (cmd.scan_step) begin
         idx_in      = idx_ff + CNT_W'(1);
         prev_end_in = end_sum;
      end else if (cmd.ins_start) begin
         pos_in = idx_ff;
         idx_in = count_ff - CNT_W'(1);
      end else if (cmd.del_start || cmd.dn_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if (cmd.up_step) begin
         idx_in = idx_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff  <= is_free_in;
      size_ff     <= size_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      prev_end_ff <= prev_end_in;
   end

   // Entry count and heap size.
   always_comb begin
      count_in = count_ff;
      if (cmd.ins_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del_done) begin
         count_in = count_ff - CNT_W'(1);
      end
      heap_in = csr_we ? csr_data : heap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         heap_ff  <= HEAP_SIZE_RESET;
      end else begin
         count_ff <= count_in;
         heap_ff  <= heap_in;
      end
   end

   // Response payload; the granted base is only given for a placed block.
   always_comb begin
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      if (cmd.rsp_load) begin
         rsp_status_in = cmd.rsp_status;
         if (cmd.rsp_status == ST_OK && !is_free_ff) begin
            rsp_granted_in = prev_end_ff[SIZE_W-1:0];
         end else begin
            rsp_granted_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;

endmodule

### rtl/ffba_controller.sv
// ----------------------------------------------------------------------------
// ffba_controller
// Sequencer of the first-fit block allocator: scans the table, drives the
// entry shifts for insert and remove, and hands results to the output stage.
// ----------------------------------------------------------------------------
module ffba_controller
   import ffba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SH_UP = 7'b0000100,
      S_INS   = 7'b0001000,
      S_SH_DN = 7'b0010000,
      S_DEL   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // The output register can take a result when empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.is_free) begin
               // Look for an exact base match.
               if (sts.at_end) begin
                  status_in = ST_NO_BASE;
                  state_in  = S_DONE;
               end else if (sts.match) begin
                  status_in = ST_OK;
                  if (sts.idx_last) begin
                     state_in = S_DEL;
                  end else begin
                     cmd.del_start = 1'b1;
                     state_in      = S_SH_DN;
                  end
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end else if (sts.zero_size || sts.full) begin
               status_in = ST_REJECT;
               state_in  = S_DONE;
            end else if (sts.fit) begin
               // First gap that holds the request.
               status_in     = ST_OK;
               cmd.ins_start = 1'b1;
               state_in      = sts.at_end ? S_INS : S_SH_UP;
            end else if (sts.at_end) begin
               status_in = ST_NO_SPACE;
               state_in  = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SH_UP: begin
            cmd.up_step = 1'b1;
            if (sts.idx_at_pos) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            cmd.ins_write = 1'b1;
            state_in      = S_DONE;
         end
         S_SH_DN: begin
            cmd.dn_step = 1'b1;
            if (sts.idx_last) begin
               state_in = S_DEL;
            end
         end
         S_DEL: begin
            cmd.del_done = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid follows loads and completed transfers.
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

endmodule

### rtl/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator of address ranges in a heap starting at address 0,
// with a sorted table of allocated blocks.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata {free_base, request_size}, tuser command
// rsp      out  rsp_tvalid/tready     tdata granted_base, tuser status
// csr      in   csr_valid/csr_ready   csr_data heap size
//
// A request scans the table entry by entry until it finds a fit, the base to
// free or the end of the table; a placed block then moves each later entry up
// by one slot and writes the new entry, and a free moves each later entry down
// by one slot and shrinks the table. Each cycle reads one table entry and
// writes at most one. Reset empties the table and sets the heap size to 10000;
// no clearing pass is needed. A new request is taken while the previous result
// still waits in the output register.
module first_fit_block_allocator_core
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,  // [15:0] request_size, [31:16] free_base
   input  logic                req_tuser,  // [0] command
   // Response channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,  // [15:0] granted_base
   output logic [STATUS_W-1:0] rsp_tuser,  // [1:0] status
   // Configuration write channel.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [HEAP_W-1:0]   csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Configuration writes complete at once.
   assign csr_ready = 1'b1;

   ffba_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_tuser),
      .req_size    (req_tdata[15:0]),
      .req_base    (req_tdata[31:16]),
      .csr_we      (csr_valid & csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_status  (rsp_tuser),
      .rsp_granted (rsp_tdata)
   );

endmodule
